// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the array list RTL
// Clocked property checks with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/iadu_pkg.sv =====
// ----------------------------------------------------------------------------
// iadu_pkg
// Item types, status codes and command/status structs for the array list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iadu_pkg;

    localparam int C_DEPTH  = 16;
    localparam int C_CNT_W  = 5;
    localparam int C_IDX_W  = $clog2(C_DEPTH);
    localparam int C_WORD_W = 32;

    localparam logic [C_CNT_W-1:0] C_FULL_CNT = C_CNT_W'(C_DEPTH);

    // operation codes
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_DELETE  = 2'd1;
    localparam logic [1:0] KIND_DISPLAY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [C_WORD_W-1:0] value;
        logic [C_CNT_W-1:0]         position;
    } t_item_in;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [C_WORD_W-1:0] entry;
        logic [C_IDX_W-1:0]         entry_index;
        logic [C_CNT_W-1:0]         count;
        logic                       last;
    } t_item_out;

    // controller -> datapath
    typedef struct packed {
        logic               exec;   // run the accepted item's single-result op
        logic               emit;   // load one display result
        logic [C_IDX_W-1:0] idx;
        logic               last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic               out_free;
        logic [C_CNT_W-1:0] count;
    } t_sts;

endpackage

// ===== src/iadu_datapath.sv =====
// ----------------------------------------------------------------------------
// iadu_datapath
// Word cells with parallel shift, entry count and the output item register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iadu_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iadu_pkg::t_item_in i_item,
    input  iadu_pkg::t_cmd     i_cmd,
    input  logic               i_out_stall,
    output iadu_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output iadu_pkg::t_item_out o_out_item
);
    import iadu_pkg::*;

    logic signed [C_WORD_W-1:0] r_cells [C_DEPTH];
    logic signed [C_WORD_W-1:0] n_cells [C_DEPTH];
    logic [C_CNT_W-1:0]         r_count;
    logic [C_CNT_W-1:0]         n_count;
    logic                       r_out_valid;
    t_item_out                  r_out;
    t_item_out                  exec_res;
    logic [1:0]                 exec_st;

    // single-result operations
    always_comb begin
        n_cells = r_cells;
        n_count = r_count;
        exec_st = ST_OK;
        case (i_item.kind)
            KIND_INSERT: begin
                if (r_count == C_FULL_CNT) begin
                    exec_st = ST_FULL;
                end else if (i_item.position > r_count) begin
                    exec_st = ST_BADPOS;
                end else begin
                    if (i_item.position == '0) begin
                        n_cells[0] = i_item.value;
                    end
                    for (int i = 1; i < C_DEPTH; i++) begin
                        if (C_CNT_W'(i) == i_item.position) begin
                            n_cells[i] = i_item.value;
                        end else if (C_CNT_W'(i) > i_item.position) begin
                            n_cells[i] = r_cells[i-1];
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            KIND_DELETE: begin
                if (r_count == '0) begin
                    exec_st = ST_EMPTY;
                end else if (i_item.position >= r_count) begin
                    exec_st = ST_BADPOS;
                end else begin
                    for (int i = 0; i < C_DEPTH - 1; i++) begin
                        if (C_CNT_W'(i) >= i_item.position) begin
                            n_cells[i] = r_cells[i+1];
                        end
                    end
                    n_count = r_count - 1'b1;
                end
            end
            KIND_DISPLAY: begin
                // non-empty display runs through the emit path
                if (r_count == '0) begin
                    exec_st = ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
        exec_res.status      = exec_st;
        exec_res.entry       = '0;
        exec_res.entry_index = '0;
        exec_res.count       = n_count;
        exec_res.last        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cells <= n_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= exec_res;
        end else if (i_cmd.emit) begin
            r_out.status      <= ST_OK;
            r_out.entry       <= r_cells[i_cmd.idx];
            r_out.entry_index <= i_cmd.idx;
            r_out.count       <= r_count;
            r_out.last        <= i_cmd.last;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.count    = r_count;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

    `ASSERT_RST(a_count_range, r_count <= C_FULL_CNT, "count above depth")
    `ASSERT_RST(a_taken_drops, (r_out_valid && !i_out_stall && !i_cmd.exec && !i_cmd.emit)
        |=> !r_out_valid, "taken item left valid")

endmodule

// ===== src/iadu_ctrl.sv =====
// ----------------------------------------------------------------------------
// iadu_ctrl
// Sequencer: accepts items and steps through the display read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iadu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_kind,
    input  iadu_pkg::t_sts i_sts,
    output logic           o_in_stall,
    output iadu_pkg::t_cmd o_cmd
);
    import iadu_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } t_state;

    t_state             r_state;
    logic [C_IDX_W-1:0] r_idx;
    logic               accept;
    logic               disp_go;
    logic               disp_last;

    assign o_in_stall = !(r_state == S_IDLE && i_sts.out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign disp_go    = (i_kind == KIND_DISPLAY) && (i_sts.count != '0);
    assign disp_last  = ({1'b0, r_idx} + 1'b1) == i_sts.count;

    assign o_cmd.exec = accept && !disp_go;
    assign o_cmd.emit = (r_state == S_DISP) && i_sts.out_free;
    assign o_cmd.idx  = r_idx;
    assign o_cmd.last = disp_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && disp_go) begin
                        r_state <= S_DISP;
                        r_idx   <= '0;
                    end
                end
                S_DISP: begin
                    if (o_cmd.emit) begin
                        if (disp_last) begin
                            r_state <= S_IDLE;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_RST(a_disp_blocks, (r_state == S_DISP) |-> o_in_stall, "item taken during display")
    `ASSERT_ALW(a_cmd_excl, !(o_cmd.exec && o_cmd.emit), "exec and emit together")
    `ASSERT_RST(a_idx_range, (r_state == S_DISP) |-> ({1'b0, r_idx} < i_sts.count),
        "display index past count")

endmodule

// ===== src/indexed_array_insert_delete_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_array_insert_delete_unit
// Packed list of up to 16 signed words with insert, delete and display.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | item
//  --------+-----+---------------------------+---------------------------
//  in      | in  | i_in_valid / o_in_stall   | kind, value, position
//  out     | out | o_out_valid / i_out_stall | status, entry, entry_index,
//          |     |                           | count, last
//
//  Insert, delete, an empty display and the odd kinds give one item each.
//  A non-empty display gives one item per cycle unless the out side
//  stalls, count items in all; the input stalls until the last is loaded.
//  Output stage is a single register; a new input is taken while the
//  previous item waits, as long as the out side is not stalling.
//  Synchronous active-low reset empties the list; words need no clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_array_insert_delete_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  iadu_pkg::t_item_in  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output iadu_pkg::t_item_out o_out_item
);
    import iadu_pkg::*;

    t_cmd cmd;   // sequencer commands
    t_sts sts;   // datapath status: output slot free, current count

    // control: accept, display walk
    iadu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_item.kind),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // storage, shifting and result register
    iadu_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/iadu_list_checker.sv =====
// ----------------------------------------------------------------------------
// iadu_list_checker
// Watches both channels of the array list, keeps its own copy of the list,
// predicts every result item and compares what comes out field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iadu_list_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  iadu_pkg::t_item_in  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  iadu_pkg::t_item_out i_out_item,
    output int                  o_fail_cnt,
    output int                  o_pending,
    output int                  o_list_len,
    output int                  o_result_cnt,
    output int                  o_full_seen,
    output int                  o_empty_seen,
    output int                  o_badpos_seen
);
    import iadu_pkg::*;

    logic signed [C_WORD_W-1:0] words [C_DEPTH];
    logic [C_CNT_W-1:0]         word_cnt;
    t_item_out                  list_replies [$];
    t_item_out                  want;

    task automatic push_reply(input logic [1:0] st, input logic signed [C_WORD_W-1:0] word,
                              input logic [C_IDX_W-1:0] idx, input logic fin);
        list_replies.push_back('{status: st, entry: word, entry_index: idx,
                                 count: word_cnt, last: fin});
        if (st == ST_FULL) o_full_seen++;
        if (st == ST_EMPTY) o_empty_seen++;
        if (st == ST_BADPOS) o_badpos_seen++;
    endtask

    // one accepted item: update the list copy, queue the replies it causes
    task automatic apply_list_op(input t_item_in it);
        int k;
        case (it.kind)
            KIND_INSERT: begin
                if (word_cnt == C_FULL_CNT) begin
                    push_reply(ST_FULL, '0, '0, 1'b1);
                end else if (it.position > word_cnt) begin
                    push_reply(ST_BADPOS, '0, '0, 1'b1);
                end else begin
                    for (k = int'(word_cnt); k > int'(it.position); k--)
                        words[k] = words[k-1];
                    words[it.position] = it.value;
                    word_cnt++;
                    push_reply(ST_OK, '0, '0, 1'b1);
                end
            end
            KIND_DELETE: begin
                if (word_cnt == '0) begin
                    push_reply(ST_EMPTY, '0, '0, 1'b1);
                end else if (it.position >= word_cnt) begin
                    push_reply(ST_BADPOS, '0, '0, 1'b1);
                end else begin
                    for (k = int'(it.position); k < int'(word_cnt) - 1; k++)
                        words[k] = words[k+1];
                    word_cnt--;
                    push_reply(ST_OK, '0, '0, 1'b1);
                end
            end
            KIND_DISPLAY: begin
                if (word_cnt == '0) begin
                    push_reply(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (k = 0; k < int'(word_cnt); k++)
                        push_reply(ST_OK, words[k], C_IDX_W'(k), k == int'(word_cnt) - 1);
                end
            end
            default: begin
                push_reply(ST_OK, '0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            o_fail_cnt++;
        end
    endtask

    // outputs are registered, so a result never belongs to the item taken
    // at the same edge; check first, then predict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_cnt = '0;
            list_replies.delete();
            o_fail_cnt = 0;
            o_result_cnt = 0;
            o_full_seen = 0;
            o_empty_seen = 0;
            o_badpos_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (list_replies.size() == 0) begin
                    $error("result item with nothing expected: %p", i_out_item);
                    o_fail_cnt++;
                end else begin
                    want = list_replies.pop_front();
                    check_field("status", want.status, i_out_item.status);
                    check_field("entry", want.entry, i_out_item.entry);
                    check_field("entry_index", want.entry_index, i_out_item.entry_index);
                    check_field("count", want.count, i_out_item.count);
                    check_field("last", want.last, i_out_item.last);
                    o_result_cnt++;
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_list_op(i_in_item);
        end
        o_pending = list_replies.size();
        o_list_len = int'(word_cnt);
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the array list with directed and random insert, delete and display
// items under random idling on both channels; a checker beside the block
// predicts and compares every result item, this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import iadu_pkg::*;

    // kind 3 has no code in the package; the block treats it as a no-op
    localparam logic [1:0] KIND_NOP = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
    localparam int LONG_HOLD      = 150;   // receiver hold-off, fills the block
    localparam int TAIL_CYCLES    = 40;    // tail margin; a full display is 16 items
    localparam int RAND_ITEMS     = 300;
    localparam int PHASE_LEN      = 30;

    // random phases lean toward filling, draining, or neither
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_item_in  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_item_out o_out_item;

    int fail_cnt;
    int pending;
    int list_len;
    int result_cnt;
    int full_seen;
    int empty_seen;
    int badpos_seen;

    int kind_cnt [4];
    bit tx_quiet;           // sender idles not at all in this phase
    bit rx_quiet;           // receiver never stalls in this phase
    int rx_hold_cycles;     // one-shot long hold-off request for the receiver

    indexed_array_insert_delete_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    iadu_list_checker list_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_list_len   (list_len),
        .o_result_cnt (result_cnt),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen),
        .o_badpos_seen(badpos_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sender side. Everything changes at the falling edge; acceptance is
    // judged at the rising edge from valid and the block's stall.
    // valid stays high straight into the next item when no gap is drawn,
    // so it is never dropped and raised in one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [C_WORD_W-1:0] word,
                             input logic [C_CNT_W-1:0] pos);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{kind: op, value: word, position: pos};
        do @(posedge i_clk); while (o_in_stall);
        kind_cnt[op]++;
        @(negedge i_clk);
    endtask

    // hold off until every queued result has come out
    task automatic wait_list_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // random item; most positions are legal for the current length,
    // some are drawn over the whole 5-bit field
    task automatic random_op(input t_mix mix);
        int roll;
        int ins_top;
        logic [1:0] op;
        logic [C_CNT_W-1:0] pos;
        ins_top = (mix == MIX_FILL) ? 76 : (mix == MIX_DRAIN) ? 31 : 56;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            op = KIND_DISPLAY;
        else if (roll < 11)
            op = KIND_NOP;
        else if (roll < ins_top)
            op = KIND_INSERT;
        else
            op = KIND_DELETE;
        if ($urandom_range(0, 99) < 12)
            pos = C_CNT_W'($urandom_range(0, 31));
        else if (op == KIND_INSERT)
            pos = C_CNT_W'($urandom_range(0, list_len));
        else
            pos = (list_len > 0) ? C_CNT_W'($urandom_range(0, list_len - 1)) : '0;
        send_item(op, $urandom, pos);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: a random stall before each result item, none in quiet
    // phases, and once a long hold-off while the sender keeps going.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall_len;
        bit hold_done;
        i_out_stall = 1'b0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!hold_done && rx_hold_cycles > 0) begin
                stall_len = rx_hold_cycles;
                hold_done = 1'b1;
            end else begin
                stall_len = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no item moves on either channel for too
    // long. The longest legal quiet stretch is the long hold-off.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int ph;
        int n;
        t_mix mix;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        rx_hold_cycles = 0;
        kind_cnt   = '{default: 0};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list rejects, bad positions, word extremes,
        // insert at front, middle and end, delete at front, middle and end
        send_item(KIND_DISPLAY, 32'h0, 5'd0);          // display of empty list
        send_item(KIND_DELETE, 32'hFFFF_FFFF, 5'd0);   // delete from empty list
        send_item(KIND_INSERT, 32'h1234_5678, 5'd1);   // past end of empty list
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 5'd31);  // all position bits set
        send_item(KIND_INSERT, 32'h8000_0000, 5'd0);   // most negative word
        send_item(KIND_INSERT, 32'h7FFF_FFFF, 5'd1);   // most positive, at end
        send_item(KIND_INSERT, 32'h0000_0000, 5'd0);   // zero at front
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 5'd3);   // -1 appended
        send_item(KIND_INSERT, 32'h5555_5555, 5'd2);   // into the middle
        send_item(KIND_INSERT, 32'hAAAA_AAAA, 5'd6);   // one past the end
        send_item(KIND_DISPLAY, 32'hAAAA_AAAA, 5'd31);
        send_item(KIND_DELETE, 32'h0, 5'd5);           // position equal to count
        send_item(KIND_DELETE, 32'h0, 5'd31);
        send_item(KIND_NOP, 32'hAAAA_AAAA, 5'd31);
        send_item(KIND_NOP, 32'h5555_5555, 5'd0);
        send_item(KIND_DELETE, 32'h0, 5'd0);           // front
        send_item(KIND_DELETE, 32'h0, 5'd3);           // back
        send_item(KIND_DELETE, 32'h0, 5'd1);           // middle
        send_item(KIND_DISPLAY, 32'h0, 5'd0);
        send_item(KIND_DELETE, 32'h0, 5'd0);
        send_item(KIND_DELETE, 32'h0, 5'd0);           // list empty again
        send_item(KIND_DISPLAY, 32'h0, 5'd0);
        wait_list_idle();

        // random phases; fill phases lean toward full, drain phases toward empty
        for (ph = 0; ph < RAND_ITEMS / PHASE_LEN; ph++) begin
            mix = (ph % 3 == 0) ? MIX_FILL : (ph % 3 == 1) ? MIX_DRAIN : MIX_EVEN;
            if (ph == 1) begin
                mix = MIX_EVEN;     // list is well filled: displays back up
                rx_quiet = 1'b0;
                tx_quiet = 1'b1;
                rx_hold_cycles = LONG_HOLD;
            end else begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            for (n = 0; n < PHASE_LEN; n++)
                random_op(mix);
            if (ph % 4 == 3)
                wait_list_idle();
        end

        // let the last results out, then idle before the report
        wait_list_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d inserts, %0d deletes, %0d displays, %0d no-ops; %0d results checked",
                 kind_cnt[KIND_INSERT], kind_cnt[KIND_DELETE], kind_cnt[KIND_DISPLAY],
                 kind_cnt[KIND_NOP], result_cnt);
        $display("Rejects seen: %0d full, %0d empty, %0d bad position; %0d mismatches",
                 full_seen, empty_seen, badpos_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/iadu_pkg.sv
src/iadu_datapath.sv
src/iadu_ctrl.sv
src/indexed_array_insert_delete_unit.sv
tb/iadu_list_checker.sv
tb/tb.sv
